// ===== src/hcbd_pkg.sv =====
// Shared types and constants for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

	localparam int SIZE_WIDTH_DEF = 32;
	localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_BAD   = 2'd1,
		ERR_LARGE = 2'd2
	} err_t;

	typedef enum logic [6:0] {
		PH_SIZE    = 7'b0000001,
		PH_SIZE_CR = 7'b0000010,
		PH_DATA    = 7'b0000100,
		PH_DATA_CR = 7'b0001000,
		PH_DATA_LF = 7'b0010000,
		PH_DONE    = 7'b0100000,
		PH_ERROR   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] body_byte;
		logic       finished;
		err_t       error_code;
	} res_t;

endpackage

`default_nettype wire

// ===== src/hcbd_core.sv =====
// Decoder state and the per-byte state update.
`default_nettype none

module hcbd_core import hcbd_pkg::*; #(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  in_byte,
	input  wire logic        start_of_message,
	input  wire logic [31:0] max_body_size,
	output res_t             res
);

	localparam int CMP_W = (SIZE_WIDTH > 32) ? SIZE_WIDTH : 32;

	phase_t                  phase_q, phase_e, phase_n;
	logic [SIZE_WIDTH-1:0]   size_accum_q, accum_e, accum_n;
	logic [SIZE_WIDTH-1:0]   bytes_left_q, left_e, left_n;
	logic [31:0]             body_total_q, total_e, total_n;
	logic [1:0]              line_chars_q, lc_e, lc_n;
	logic                    line_is_zero_q, liz_e, liz_n;
	logic                    hex_ended_q, he_e, he_n;
	err_t                    err_q, err_e, err_n;
	logic                    do_char, do_end;
	logic [4:0]              digit;
	logic [CMP_W-1:0]        accum_ext, room_ext;
	logic                    out_valid_byte;
	logic [7:0]              out_data;

	// bit 4 flags a hex digit, bits 3:0 carry its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		case (c) inside
			[8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
			[8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
			[8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
			default:       r = '0;
		endcase
		return r;
	endfunction

	assign digit = hex_digit(in_byte);

	always_comb begin
		// a start flag clears everything but the limit register
		phase_e = start_of_message ? PH_SIZE : phase_q;
		accum_e = start_of_message ? '0 : size_accum_q;
		left_e  = start_of_message ? '0 : bytes_left_q;
		total_e = start_of_message ? '0 : body_total_q;
		lc_e    = start_of_message ? '0 : line_chars_q;
		liz_e   = start_of_message ? 1'b0 : line_is_zero_q;
		he_e    = start_of_message ? 1'b0 : hex_ended_q;
		err_e   = start_of_message ? ERR_NONE : err_q;

		phase_n = phase_e;
		accum_n = accum_e;
		left_n  = left_e;
		total_n = total_e;
		lc_n    = lc_e;
		liz_n   = liz_e;
		he_n    = he_e;
		err_n   = err_e;
		do_char = 1'b0;
		do_end  = 1'b0;
		out_valid_byte = 1'b0;
		out_data = '0;
		accum_ext = CMP_W'(accum_e);
		room_ext  = CMP_W'(max_body_size - total_e);

		case (phase_e)
			PH_SIZE: begin
				if (in_byte == CH_CR) begin
					phase_n = PH_SIZE_CR;
					he_n = 1'b1;
				end else begin
					do_char = 1'b1;
				end
			end
			PH_SIZE_CR: begin
				if (in_byte == CH_LF) begin
					do_end = 1'b1;
				end else begin
					// the held CR was a lone CR: count it as line text
					liz_n = 1'b0;
					if (lc_n != 2'd3) lc_n = lc_n + 2'd1;
					if (in_byte != CH_CR) begin
						phase_n = PH_SIZE;
						do_char = 1'b1;
					end
				end
			end
			PH_DATA: begin
				out_valid_byte = 1'b1;
				out_data = in_byte;
				if (left_e != '0) left_n = left_e - 1'b1;
				if (left_n == '0) phase_n = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				if (in_byte == CH_CR) begin
					phase_n = PH_DATA_LF;
				end else begin
					phase_n = PH_ERROR;
					err_n = ERR_BAD;
				end
			end
			PH_DATA_LF: begin
				if (in_byte == CH_LF) begin
					phase_n = PH_SIZE;
					accum_n = '0;
					lc_n = '0;
					liz_n = 1'b0;
					he_n = 1'b0;
				end else begin
					phase_n = PH_ERROR;
					err_n = ERR_BAD;
				end
			end
			default: begin
				// finished, error and unknown codes hold until a start flag
			end
		endcase

		if (do_char) begin
			liz_n = (lc_n == 2'd0) && (in_byte == CH_ZERO);
			if (lc_n != 2'd3) lc_n = lc_n + 2'd1;
			if (!he_n && digit[4]) begin
				// saturate once the top nibble is in use
				if (accum_e[SIZE_WIDTH-1 -: 4] != 4'd0) accum_n = '1;
				else accum_n = {accum_e[SIZE_WIDTH-5:0], digit[3:0]};
			end else begin
				he_n = 1'b1;
			end
		end

		if (do_end) begin
			if (lc_e == 2'd1 && liz_e) begin
				phase_n = PH_DONE;
			end else if (accum_e == '0) begin
				phase_n = PH_ERROR;
				err_n = ERR_BAD;
			end else if (accum_ext > room_ext) begin
				phase_n = PH_ERROR;
				err_n = ERR_LARGE;
			end else begin
				total_n = total_e + accum_ext[31:0];
				left_n = accum_e;
				phase_n = PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SIZE;
			size_accum_q   <= '0;
			bytes_left_q   <= '0;
			body_total_q   <= '0;
			line_chars_q   <= '0;
			line_is_zero_q <= 1'b0;
			hex_ended_q    <= 1'b0;
			err_q          <= ERR_NONE;
		end else if (step) begin
			phase_q        <= phase_n;
			size_accum_q   <= accum_n;
			bytes_left_q   <= left_n;
			body_total_q   <= total_n;
			line_chars_q   <= lc_n;
			line_is_zero_q <= liz_n;
			hex_ended_q    <= he_n;
			err_q          <= err_n;
		end
	end

	assign res.data_valid = out_valid_byte;
	assign res.body_byte  = out_data;
	assign res.finished   = (phase_n == PH_DONE);
	assign res.error_code = err_n;

endmodule

`default_nettype wire

// ===== src/http_chunked_body_decoder_unit.sv =====
// Path: an accepted byte goes into the input register; the core's result for it is registered in the result register.
// Throughput: one byte per cycle while out_ready does not stall the output; the state update (size accumulator,
// bytes-left counter, body total) sets the rate, with a result register decoupling output stalls.
// Reset: arst_n asynchronously clears the decoder to the start of a size line with no error,
// empties the input and result registers and sets max_body_size to 1048576.
// Top level of the chunked HTTP body decoder.
`default_nettype none

module http_chunked_body_decoder_unit import hcbd_pkg::*; #(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        start_of_message,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        data_valid,
	output      logic [7:0]  body_byte,
	output      logic        finished,
	output      logic [1:0]  error_code,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        som_s1;
	logic        out_valid_q;
	res_t        res_q;
	res_t        res_d;
	logic        out_free;
	logic        step;
	logic [31:0] max_body_q;

	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			som_s1  <= start_of_message;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAX_BODY_RESET;
		end else if (cfg_wr_en) begin
			max_body_q <= cfg_wr_data;
		end
	end

	hcbd_core #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.in_byte          (byte_s1),
		.start_of_message (som_s1),
		.max_body_size    (max_body_q),
		.res              (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_valid = res_q.data_valid;
	assign body_byte  = res_q.body_byte;
	assign finished   = res_q.finished;
	assign error_code = res_q.error_code;

	a_no_done_with_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(finished && error_code != ERR_NONE))
		else $error("finished reported together with an error");

	a_data_only_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> !finished && error_code == ERR_NONE)
		else $error("data byte emitted after finish or error");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while a register was free");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q))
		else $error("pending result changed before transaction");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the chunked HTTP body decoder: directed table plus random bodies.
`default_nettype none

module testbench import hcbd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] SIZE_LIMIT = {64{1'b1}} >> (64 - SIZE_WIDTH_DEF);
	localparam int ITEMS_PER_SETTING = 150;
	localparam int SETTINGS_COUNT = 5;
	localparam int LONG_HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        start_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        data_valid;
	logic [7:0]  body_byte;
	logic        finished;
	logic [1:0]  error_code;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = 32'd0;

	http_chunked_body_decoder_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.start_of_message (start_of_message),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_valid       (data_valid),
		.body_byte        (body_byte),
		.finished         (finished),
		.error_code       (error_code),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data)
	);

	always #6 clk = ~clk;

	// decoder state mirrored for prediction
	phase_t      dec_phase;
	logic [63:0] size_acc;
	logic [63:0] chunk_left;
	logic [31:0] total_len;
	logic [31:0] max_len;
	logic [1:0]  line_len;
	logic        line_zero;
	logic        hex_done;
	err_t        dec_err;

	res_t        expected_results[$];
	int          bad_results = 0;
	int          live_items = 0;

	// stimulus side-band: rows whose result is typed into the table
	logic        tag_fixed = 1'b0;
	res_t        tag_res = '0;
	logic        cur_fixed = 1'b0;
	res_t        cur_res = '0;
	logic        som_next = 1'b0;
	bit          src_burst = 1'b0;
	bit          sink_burst = 1'b0;
	bit          sink_hold_req = 1'b0;

	logic [7:0]  row_byte[$];
	logic        row_som[$];
	logic        row_fixed[$];
	res_t        row_res[$];

	function automatic int hex_digit_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic void clear_line();
		size_acc = 64'd0;
		line_len = 2'd0;
		line_zero = 1'b0;
		hex_done = 1'b0;
	endfunction

	function automatic void clear_decoder();
		dec_phase = PH_SIZE;
		clear_line();
		chunk_left = 64'd0;
		total_len = 32'd0;
		dec_err = ERR_NONE;
	endfunction

	function automatic void flag_error(err_t code);
		dec_err = code;
		dec_phase = PH_ERROR;
	endfunction

	function automatic void size_line_char(logic [7:0] c);
		int d;
		d = hex_digit_value(c);
		line_zero = (line_len == 2'd0) && (c == CH_ZERO);
		if (line_len < 2'd3) line_len++;
		if (!hex_done && d >= 0) begin
			// saturate rather than wrap
			if (size_acc > (SIZE_LIMIT - 64'(d)) / 64'd16) size_acc = SIZE_LIMIT;
			else size_acc = size_acc * 64'd16 + 64'(d);
		end else begin
			hex_done = 1'b1;
		end
	endfunction

	function automatic res_t decode_byte(logic [7:0] c, logic som);
		res_t r;
		r.data_valid = 1'b0;
		r.body_byte = 8'h00;
		if (som) clear_decoder();
		case (dec_phase)
			PH_SIZE: begin
				if (c == CH_CR) begin
					dec_phase = PH_SIZE_CR;
					hex_done = 1'b1;
				end else begin
					size_line_char(c);
				end
			end
			PH_SIZE_CR: begin
				if (c == CH_LF) begin
					if (line_len == 2'd1 && line_zero) begin
						dec_phase = PH_DONE;
					end else if (size_acc == 64'd0) begin
						flag_error(ERR_BAD);
					end else if (size_acc > {32'd0, max_len - total_len}) begin
						flag_error(ERR_LARGE);
					end else begin
						total_len = total_len + size_acc[31:0];
						chunk_left = size_acc;
						dec_phase = PH_DATA;
					end
				end else begin
					// the pending CR was a lone CR: count it as line text
					line_zero = 1'b0;
					if (line_len < 2'd3) line_len++;
					if (c != CH_CR) begin
						dec_phase = PH_SIZE;
						size_line_char(c);
					end
				end
			end
			PH_DATA: begin
				r.data_valid = 1'b1;
				r.body_byte = c;
				if (chunk_left > 64'd0) chunk_left--;
				if (chunk_left == 64'd0) dec_phase = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				if (c == CH_CR) dec_phase = PH_DATA_LF;
				else flag_error(ERR_BAD);
			end
			PH_DATA_LF: begin
				if (c == CH_LF) begin
					dec_phase = PH_SIZE;
					clear_line();
				end else begin
					flag_error(ERR_BAD);
				end
			end
			default: ;
		endcase
		r.finished = (dec_phase == PH_DONE);
		r.error_code = dec_err;
		return r;
	endfunction

	// predict every accepted input transaction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			live_items++;
			if (tag_fixed) begin
				void'(decode_byte(in_byte, start_of_message));
				expected_results.push_back(tag_res);
			end else begin
				expected_results.push_back(decode_byte(in_byte, start_of_message));
			end
		end
	end

	// compare every accepted output transaction with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result: dv=%0b byte=%02h fin=%0b err=%0d",
						data_valid, body_byte, finished, error_code);
			end else begin
				want = expected_results.pop_front();
				if (data_valid !== want.data_valid || body_byte !== want.body_byte ||
						finished !== want.finished || error_code !== want.error_code) begin
					bad_results++;
					if (bad_results <= 10) begin
						$display("mismatch: expected dv=%0b byte=%02h fin=%0b err=%0d",
							want.data_valid, want.body_byte, want.finished,
							want.error_code);
						$display("          got      dv=%0b byte=%02h fin=%0b err=%0d",
							data_valid, body_byte, finished, error_code);
					end
				end
			end
		end
	end

	// receiver: random stalls, bursts, and one long hold-off on request
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		start_of_message <= som_next;
		tag_fixed <= cur_fixed;
		tag_res <= cur_res;
		som_next = 1'b0;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_max_body(input logic [31:0] value);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len = value;
		@(posedge clk);
	endtask

	task automatic fixed_row(input logic [7:0] b, input logic som, input logic dv,
			input logic [7:0] bb, input logic fin, input err_t err);
		res_t r;
		r.data_valid = dv;
		r.body_byte = bb;
		r.finished = fin;
		r.error_code = err;
		row_byte.push_back(b);
		row_som.push_back(som);
		row_fixed.push_back(1'b1);
		row_res.push_back(r);
	endtask

	task automatic pred_row(input logic [7:0] b, input logic som);
		row_byte.push_back(b);
		row_som.push_back(som);
		row_fixed.push_back(1'b0);
		row_res.push_back('0);
	endtask

	function automatic logic [7:0] random_byte_except(logic [7:0] avoid);
		logic [7:0] r;
		do r = 8'($urandom_range(0, 255)); while (r == avoid);
		return r;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10) return CH_ZERO + 8'(nib);
		return ($urandom_range(0, 1) ? "A" : "a") + 8'(nib - 4'd10);
	endfunction

	task automatic send_size_line(input logic [31:0] len, input bit oversize);
		int nd;
		if ($urandom_range(0, 4) == 0) send_byte(CH_ZERO);
		if (oversize) begin
			nd = $urandom_range(9, 11);
			send_byte(hex_char(4'($urandom_range(1, 15))));
			repeat (nd - 1) send_byte(hex_char(4'($urandom_range(0, 15))));
		end else begin
			nd = 8;
			while (nd > 1 && len[4*nd-1 -: 4] == 4'd0) nd--;
			for (int i = nd - 1; i >= 0; i--) send_byte(hex_char(len[4*i +: 4]));
		end
		case ($urandom_range(0, 5))
			0: begin
				send_byte(";");
				repeat ($urandom_range(0, 3)) send_byte(random_byte_except(CH_CR));
			end
			1: begin
				// lone CR inside the line
				send_byte(CH_CR);
				send_byte(random_byte_except(CH_LF));
			end
			default: ;
		endcase
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_chunked_body(input bit broken);
		int chunks;
		logic [31:0] len;
		bit huge;
		som_next = 1'b1;
		src_burst = ($urandom_range(0, 4) == 0);
		chunks = $urandom_range(0, 4);
		for (int k = 0; k < chunks; k++) begin
			huge = ($urandom_range(0, 19) == 0);
			if (huge) len = $urandom;
			else if ($urandom_range(0, 6) == 0) len = $urandom_range(13, 40);
			else len = $urandom_range(1, 12);
			send_size_line(len, huge && $urandom_range(0, 1));
			if (huge) begin
				// a huge chunk is cut short; the next message restarts the decoder
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
				return;
			end
			repeat (len) send_byte(8'($urandom_range(0, 255)));
			if (broken && $urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 1)) begin
					send_byte(random_byte_except(CH_CR));
				end else begin
					send_byte(CH_CR);
					send_byte(random_byte_except(CH_LF));
				end
			end else begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
		end
		if (broken && $urandom_range(0, 1)) begin
			case ($urandom_range(0, 3))
				0: ;
				1: begin send_byte(CH_ZERO); send_byte(CH_ZERO); end
				2: begin send_byte(CH_ZERO); send_byte(";"); send_byte("x"); end
				default: send_byte("x");
			endcase
		end else begin
			send_byte(CH_ZERO);
		end
		send_byte(CH_CR);
		send_byte(CH_LF);
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [31:0] setting;
		int target;
		int roll;
		max_len = MAX_BODY_RESET;
		clear_decoder();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; first row checks the state left by reset
		fixed_row("0", 1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE);
		pred_row(CH_CR, 1'b0);
		fixed_row(CH_LF, 1'b0, 1'b0, 8'h00, 1'b1, ERR_NONE);
		fixed_row("A", 1'b0, 1'b0, 8'h00, 1'b1, ERR_NONE);
		pred_row("2", 1'b1);
		pred_row(CH_CR, 1'b0);
		pred_row("g", 1'b0);
		pred_row(CH_CR, 1'b0);
		pred_row(CH_LF, 1'b0);
		fixed_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, ERR_NONE);
		fixed_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ERR_NONE);
		fixed_row("Z", 1'b0, 1'b0, 8'h00, 1'b0, ERR_BAD);
		fixed_row(CH_CR, 1'b0, 1'b0, 8'h00, 1'b0, ERR_BAD);
		pred_row("f", 1'b1);
		for (int i = 0; i < 8; i++) pred_row((i % 2) ? "f" : "F", 1'b0);
		pred_row(CH_CR, 1'b0);
		fixed_row(CH_LF, 1'b0, 1'b0, 8'h00, 1'b0, ERR_LARGE);
		pred_row(CH_CR, 1'b1);
		fixed_row(CH_LF, 1'b0, 1'b0, 8'h00, 1'b0, ERR_BAD);

		foreach (row_byte[i]) begin
			som_next = row_som[i];
			cur_fixed = row_fixed[i];
			cur_res = row_res[i];
			send_byte(row_byte[i]);
		end
		cur_fixed = 1'b0;
		cur_res = '0;

		for (int p = 0; p < SETTINGS_COUNT; p++) begin
			wait_for_results();
			case (p)
				0: setting = MAX_BODY_RESET;
				1: setting = 32'd0;
				2: setting = 32'hFFFF_FFFF;
				3: setting = 32'd40;
				default: setting = $urandom_range(60, 400);
			endcase
			write_max_body(setting);
			// fill the block while the receiver is held off
			if (p == 2) sink_hold_req = 1'b1;
			target = live_items + ITEMS_PER_SETTING;
			while (live_items < target) begin
				roll = $urandom_range(0, 9);
				if (roll < 8) begin
					send_chunked_body(1'b0);
				end else if (roll == 8) begin
					send_chunked_body(1'b1);
				end else begin
					src_burst = 1'b0;
					repeat ($urandom_range(4, 16)) begin
						som_next = ($urandom_range(0, 7) == 0);
						send_byte(8'($urandom_range(0, 255)));
					end
				end
			end
		end

		wait_for_results();
		repeat (4) @(posedge clk);
		if (bad_results == 0 && expected_results.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/hcbd_pkg.sv
src/hcbd_core.sv
src/http_chunked_body_decoder_unit.sv
tb/testbench.sv
